// File: src/drs_pkg.sv
// Shared constants, codes and types of the drift corrected ring resampler.
package drs_pkg;

    localparam int RING_FRAMES_DEF = 8192;
    localparam int MAX_BLOCK_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int POS_W  = 48;
    localparam int FRAC_W = 32;
    localparam int LAT_W  = 12;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 3;
    localparam int TOT_W  = 32;
    localparam int STEP_W = FRAC_W + 1;
    localparam int RPROD_W = STEP_W + CNT_W;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_REQ   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [ST_W-1:0] ST_PLAY  = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLEW = 3'd1;
    localparam logic [ST_W-1:0] ST_PRIME = 3'd2;
    localparam logic [ST_W-1:0] ST_OVER  = 3'd3;
    localparam logic [ST_W-1:0] ST_UNDER = 3'd4;

    localparam logic [LAT_W-1:0] LAT_MIN   = 12'd256;
    localparam logic [LAT_W-1:0] LAT_RESET = 12'd1024;
    localparam logic [FRAC_W-1:0] CORR_LIMIT = 32'd21474836;

    typedef struct packed {
        logic [1:0]       op;
        logic [CNT_W-1:0] n;
    } drs_cmd_t;

endpackage

// File: src/drs_ifs.sv
// Handshake interfaces for the item, result and configuration channels.
interface drs_item_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [6:0]                    frame_count;
    modport source (output valid, operation, left_in, right_in, frame_count, input ready);
    modport sink (input valid, operation, left_in, right_in, frame_count, output ready);
endinterface

interface drs_result_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [2:0]                    status;
    logic                          last_frame;
    logic [31:0]                   resync_total;
    logic [31:0]                   underrun_total;
    modport source (output valid, left_out, right_out, status, last_frame, resync_total,
                    underrun_total, input ready);
    modport sink (input valid, left_out, right_out, status, last_frame, resync_total,
                  underrun_total, output ready);
endinterface

interface drs_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] target_latency;
    modport source (output valid, target_latency, input ready);
    modport sink (input valid, target_latency, output ready);
endinterface

// File: src/drs_front.sv
// Front part: accepts words, classifies them and queues them for the back part.
module drs_front
    import drs_pkg::*;
#(
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    drs_item_if.sink               items,
    output logic                   q_valid,
    input  logic                   q_ready,
    output drs_cmd_t               q_cmd,
    output logic [SAMPLE_BITS-1:0] q_left,
    output logic [SAMPLE_BITS-1:0] q_right
);

    localparam int DEPTH = 4;
    localparam int PW    = 2;
    localparam int EW    = $bits(drs_cmd_t) + 2 * SAMPLE_BITS;

    logic [EW-1:0] queue_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    drs_cmd_t      cmd;
    logic          push, pop, keep;

    always_comb
    begin
        cmd.op = items.operation;
        cmd.n  = (items.frame_count > CNT_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : items.frame_count;
    end

    // A request for zero frames does nothing, so it is not queued.
    assign keep    = !(items.operation == OP_REQ && items.frame_count == '0);
    assign items.ready = (count_reg != (PW+1)'(DEPTH));
    assign push    = items.valid && items.ready && keep;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign {q_cmd, q_left, q_right} = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= {cmd, items.left_in, items.right_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// File: src/drs_back.sv
// Back part: ring memory, stream control, drift divider and interpolating output.
module drs_back
    import drs_pkg::*;
#(
    parameter int RING_FRAMES = RING_FRAMES_DEF,
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  drs_cmd_t               q_cmd,
    input  logic [SAMPLE_BITS-1:0] q_left,
    input  logic [SAMPLE_BITS-1:0] q_right,
    drs_cfg_if.sink                cfg,
    drs_result_if.source           results
);

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = $clog2(RING_FRAMES);
    localparam int AV_W   = (AW + 1 > LAT_W) ? AW + 1 : LAT_W;
    localparam int NUM_W  = AV_W + FRAC_W;
    localparam int DIV_W  = LAT_W + 7;
    localparam int DC_W   = $clog2(NUM_W + 1);
    localparam int LAT_HI = (RING_FRAMES / 4 > 4095) ? 4095 : RING_FRAMES / 4;
    localparam int IP_W   = SB + 1 + STEP_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_STEP = 4'd3;
    localparam logic [3:0] S_MULQ = 4'd4;
    localparam logic [3:0] S_UND  = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_SIL  = 4'd9;

    logic [2*SB-1:0] ring [RING_FRAMES];
    logic [2*SB-1:0] rd0_reg, rd1_reg;

    logic [3:0]         state_reg, state_next;
    logic [POS_W-1:0]   wp_reg, wp_next, ss_reg, ss_next, ri_reg, ri_next;
    logic [AW-1:0]      wslot_reg, wslot_next, sslot_reg, sslot_next;
    logic [AW-1:0]      rslot_reg, rslot_next, rslot1, rslot2;
    logic [FRAC_W-1:0]  rf_reg, rf_next;
    logic               sync_reg, sync_next, wact_reg, wact_next;
    logic [TOT_W-1:0]   rsc_reg, rsc_next, urc_reg, urc_next;
    logic [LAT_W-1:0]   tgt_reg, tgt_next;
    logic [CNT_W-1:0]   n_reg, n_next, k_reg, k_next;
    logic [ST_W-1:0]    st_reg, st_next;
    logic [AV_W-1:0]    avail_reg, avail_next;
    logic               neg_reg, neg_next;
    logic [DIV_W-1:0]   div_reg, div_next, rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [DC_W-1:0]    dcnt_reg, dcnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [RPROD_W-1:0] rprod_reg, rprod_next;
    logic [IP_W-1:0]    pl_reg, pl_next, pr_reg, pr_next;

    logic               ov_reg, ov_next, lf_reg, lf_next;
    logic [SB-1:0]      ol_reg, ol_next, or_reg, or_next;
    logic [ST_W-1:0]    os_reg, os_next;
    logic [TOT_W-1:0]   ort_reg, ort_next, out_reg, out_next;

    logic               ring_we, out_free;
    logic [POS_W-1:0]   gap, r_pos;
    logic [AW-1:0]      r_slot;
    logic [AV_W-1:0]    mag;
    logic [DIV_W:0]     shifted;
    logic [FRAC_W-1:0]  corr;
    logic [FRAC_W+1:0]  fsum;
    logic [9:0]         required;
    logic [SB:0]        dl, dr;
    logic [LAT_W-1:0]   cfg_clamped;

    assign out_free = !ov_reg || results.ready;
    assign q_ready  = (state_reg == S_IDLE);
    assign ring_we  = q_valid && q_ready && q_cmd.op == OP_PUSH;
    assign rslot1   = (rslot_reg == AW'(RING_FRAMES - 1)) ? '0 : rslot_reg + 1'b1;
    assign rslot2   = (rslot1 == AW'(RING_FRAMES - 1)) ? '0 : rslot1 + 1'b1;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_clamped = cfg.target_latency;
        if (cfg_clamped < LAT_MIN)
        begin
            cfg_clamped = LAT_MIN;
        end
        if (cfg_clamped > LAT_W'(LAT_HI))
        begin
            cfg_clamped = LAT_W'(LAT_HI);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[wslot_reg] <= {q_left, q_right};
        end
        rd0_reg <= ring[rslot_reg];
        rd1_reg <= ring[rslot1];
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next = wp_reg;  ss_next = ss_reg;  ri_next = ri_reg;
        wslot_next = wslot_reg;  sslot_next = sslot_reg;  rslot_next = rslot_reg;
        rf_next = rf_reg;  sync_next = sync_reg;  wact_next = wact_reg;
        rsc_next = rsc_reg;  urc_next = urc_reg;  tgt_next = tgt_reg;
        n_next = n_reg;  k_next = k_reg;  st_next = st_reg;
        avail_next = avail_reg;  neg_next = neg_reg;  div_next = div_reg;
        rem_next = rem_reg;  quo_next = quo_reg;  dcnt_next = dcnt_reg;
        step_next = step_reg;  rprod_next = rprod_reg;
        pl_next = pl_reg;  pr_next = pr_reg;
        ov_next = ov_reg && !results.ready;
        lf_next = lf_reg;  ol_next = ol_reg;  or_next = or_reg;  os_next = os_reg;
        ort_next = ort_reg;  out_next = out_reg;

        gap = wp_reg - ss_reg;
        r_pos = wp_reg - POS_W'(tgt_reg);
        r_slot = (wslot_reg >= AW'(tgt_reg)) ? wslot_reg - AW'(tgt_reg)
                 : AW'(RING_FRAMES + 32'(wslot_reg) - 32'(tgt_reg));
        if (r_pos < ss_reg)
        begin
            r_pos  = ss_reg;
            r_slot = sslot_reg;
        end
        mag = neg_reg ? AV_W'(tgt_reg) - avail_reg : avail_reg - AV_W'(tgt_reg);
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        corr = (quo_reg > NUM_W'(CORR_LIMIT)) ? CORR_LIMIT : quo_reg[FRAC_W-1:0];
        required = 10'(rprod_reg[RPROD_W-1:FRAC_W]) + 10'(|rprod_reg[FRAC_W-1:0]) + 10'd2;
        fsum = {2'b00, rf_reg} + (FRAC_W+2)'(step_reg);
        dl = {rd1_reg[2*SB-1], rd1_reg[2*SB-1:SB]} - {rd0_reg[2*SB-1], rd0_reg[2*SB-1:SB]};
        dr = {rd1_reg[SB-1], rd1_reg[SB-1:0]} - {rd0_reg[SB-1], rd0_reg[SB-1:0]};

        if (cfg.valid)
        begin
            tgt_next = cfg_clamped;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_PUSH:
                        begin
                            wp_next = wp_reg + 1'b1;
                            wslot_next = (wslot_reg == AW'(RING_FRAMES - 1)) ? '0
                                         : wslot_reg + 1'b1;
                        end
                        OP_START:
                        begin
                            ss_next = wp_reg;
                            sslot_next = wslot_reg;
                            wact_next = 1'b1;
                            sync_next = 1'b0;
                        end
                        OP_STOP:
                        begin
                            wact_next = 1'b0;
                        end
                        default:
                        begin
                            n_next = q_cmd.n;
                            k_next = '0;
                            if (!wact_reg)
                            begin
                                sync_next = 1'b0;
                                st_next = ST_IDLEW;
                                state_next = S_SIL;
                            end
                            else if (wp_reg < ss_reg || gap < POS_W'(tgt_reg))
                            begin
                                st_next = ST_PRIME;
                                state_next = S_SIL;
                            end
                            else
                            begin
                                if (!sync_reg)
                                begin
                                    ri_next = r_pos;
                                    rslot_next = r_slot;
                                    rf_next = '0;
                                    sync_next = 1'b1;
                                    rsc_next = rsc_reg + 1'b1;
                                end
                                state_next = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                if (ri_reg > wp_reg || wp_reg - ri_reg >= POS_W'(RING_FRAMES - 2))
                begin
                    sync_next = 1'b0;
                    st_next = ST_OVER;
                    state_next = S_SIL;
                end
                else
                begin
                    avail_next = AV_W'(wp_reg - ri_reg);
                    neg_next = AV_W'(wp_reg - ri_reg) < AV_W'(tgt_reg);
                    div_next = DIV_W'(tgt_reg) * DIV_W'(100);
                    dcnt_next = DC_W'(NUM_W);
                    state_next = S_DIV;
                    rem_next = '0;
                    quo_next = '0;
                end
            end
            S_DIV:
            begin
                // The first cycle loads the magnitude; the rest divide one bit each.
                if (dcnt_reg == DC_W'(NUM_W) && rem_reg == '0 && quo_reg == '0)
                begin
                    quo_next = {mag, {FRAC_W{1'b0}}};
                    dcnt_next = dcnt_reg - 1'b1;
                    rem_next = '0;
                    if (mag == '0)
                    begin
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    if (shifted >= {1'b0, div_reg})
                    begin
                        rem_next = DIV_W'(shifted - {1'b0, div_reg});
                        quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = DIV_W'(shifted);
                        quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    if (dcnt_reg == '0)
                    begin
                        state_next = S_STEP;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg - 1'b1;
                    end
                end
            end
            S_STEP:
            begin
                step_next = neg_reg ? {1'b1, {FRAC_W{1'b0}}} - STEP_W'(corr)
                                    : {1'b1, {FRAC_W{1'b0}}} + STEP_W'(corr);
                state_next = S_MULQ;
            end
            S_MULQ:
            begin
                rprod_next = RPROD_W'(n_reg) * RPROD_W'(step_reg);
                state_next = S_UND;
            end
            S_UND:
            begin
                if (32'(avail_reg) < 32'(required))
                begin
                    urc_next = urc_reg + 1'b1;
                    st_next = ST_UNDER;
                    state_next = S_SIL;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                pl_next = IP_W'($signed(dl) * $signed({1'b0, rf_reg}));
                pr_next = IP_W'($signed(dr) * $signed({1'b0, rf_reg}));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ol_next = rd0_reg[2*SB-1:SB] + pl_reg[FRAC_W +: SB];
                    or_next = rd0_reg[SB-1:0] + pr_reg[FRAC_W +: SB];
                    os_next = ST_PLAY;
                    lf_next = (k_reg + 1'b1 == n_reg);
                    ort_next = rsc_reg;
                    out_next = urc_reg;
                    rf_next = fsum[FRAC_W-1:0];
                    if (fsum[FRAC_W+1])
                    begin
                        ri_next = ri_reg + 2'd2;
                        rslot_next = rslot2;
                    end
                    else if (fsum[FRAC_W])
                    begin
                        ri_next = ri_reg + 1'b1;
                        rslot_next = rslot1;
                    end
                    k_next = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == n_reg) ? S_IDLE : S_RD;
                end
            end
            S_SIL:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ol_next = '0;
                    or_next = '0;
                    os_next = st_reg;
                    lf_next = (k_reg + 1'b1 == n_reg);
                    ort_next = rsc_reg;
                    out_next = urc_reg;
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;  k_reg <= k_next;  st_reg <= st_next;
        avail_reg <= avail_next;  neg_reg <= neg_next;  div_reg <= div_next;
        step_reg <= step_next;  rprod_reg <= rprod_next;
        pl_reg <= pl_next;  pr_reg <= pr_next;
        ol_reg <= ol_next;  or_reg <= or_next;  os_reg <= os_next;  lf_reg <= lf_next;
        ort_reg <= ort_next;  out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg <= '0;  ss_reg <= '0;  ri_reg <= '0;
            wslot_reg <= '0;  sslot_reg <= '0;  rslot_reg <= '0;
            rf_reg <= '0;  sync_reg <= 1'b0;  wact_reg <= 1'b0;
            rsc_reg <= '0;  urc_reg <= '0;
            tgt_reg <= (LAT_RESET > LAT_W'(LAT_HI)) ? LAT_W'(LAT_HI) : LAT_RESET;
            rem_reg <= '0;  quo_reg <= '0;  dcnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg <= wp_next;  ss_reg <= ss_next;  ri_reg <= ri_next;
            wslot_reg <= wslot_next;  sslot_reg <= sslot_next;  rslot_reg <= rslot_next;
            rf_reg <= rf_next;  sync_reg <= sync_next;  wact_reg <= wact_next;
            rsc_reg <= rsc_next;  urc_reg <= urc_next;  tgt_reg <= tgt_next;
            rem_reg <= rem_next;  quo_reg <= quo_next;  dcnt_reg <= dcnt_next;
            ov_reg <= ov_next;
        end
    end

    assign results.valid          = ov_reg;
    assign results.left_out       = ol_reg;
    assign results.right_out      = or_reg;
    assign results.status         = os_reg;
    assign results.last_frame     = lf_reg;
    assign results.resync_total   = ort_reg;
    assign results.underrun_total = out_reg;

endmodule

// File: src/drift_corrected_ring_resampler_core.sv
// Top level of the drift corrected ring resampler.
// Words enter on the items channel: a push stores one stereo frame in the ring,
// a start begins a new stream, a stop marks the writer idle, and a request asks
// for frame_count output frames, at most MAX_BLOCK.
// Each request gives one result word per frame on the results channel, either
// interpolated audio with status playing or silence with a status code, and the
// final word of the block carries last_frame.
// The cfg channel writes the target latency; it is clamped to the legal range and
// must only be written while the block is idle.
// A four word queue parts the front from the back, so items are taken while the
// back is busy or the receiver stalls. The back handles push, start and stop in
// its idle state. A playing request checks the fill, runs the bit serial drift
// divider (which ends early when the fill equals the target), forms the step and
// checks for underrun, then per frame reads the ring, multiplies and loads the
// output register. A silent block gives one frame per cycle while none stall.
// When the receiver stalls, the output register holds its word and the back waits.
// Reset empties the queue, clears all positions, flags and counters, and sets the
// target latency to 1024 frames; the ring holds no valid audio until pushed.
module drift_corrected_ring_resampler_core
    import drs_pkg::*;
#(
    parameter int RING_FRAMES = RING_FRAMES_DEF,
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    drs_item_if.sink     items,
    drs_result_if.source results,
    drs_cfg_if.sink      cfg
);

    logic                   q_valid, q_ready;
    drs_cmd_t               q_cmd;
    logic [SAMPLE_BITS-1:0] q_left, q_right;

    drs_front #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .q_left  (q_left),
        .q_right (q_right)
    );

    drs_back #(
        .RING_FRAMES (RING_FRAMES),
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .q_left  (q_left),
        .q_right (q_right),
        .cfg     (cfg),
        .results (results)
    );

endmodule

// File: src/drs_checker.sv
// Port level checks on the result channel, bound to the top level.
module drs_checker
    import drs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   valid,
    input logic                   ready,
    input logic [SAMPLE_BITS-1:0] left_out,
    input logic [SAMPLE_BITS-1:0] right_out,
    input logic [ST_W-1:0]        status,
    input logic                   last_frame,
    input logic [TOT_W-1:0]       resync_total,
    input logic [TOT_W-1:0]       underrun_total
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(left_out) && $stable(status))
        else $error("Stalled result word changed.");

    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_PLAY |-> left_out == '0 && right_out == '0)
        else $error("Silent word carries audio.");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> status <= ST_UNDER)
        else $error("Status code out of range.");

    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_frame ##1 valid |->
        status == $past(status) && resync_total == $past(resync_total)
        && underrun_total == $past(underrun_total))
        else $error("Status or totals changed inside a block.");

endmodule

bind drift_corrected_ring_resampler_core drs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_drs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (results.valid),
    .ready          (results.ready),
    .left_out       (results.left_out),
    .right_out      (results.right_out),
    .status         (results.status),
    .last_frame     (results.last_frame),
    .resync_total   (results.resync_total),
    .underrun_total (results.underrun_total)
);
